FILE: rtl/mmu_pkg.sv
// Shared constants, codes and command/status types for the matrix multiply unit.
`default_nettype none

package mmu_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;

   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int KIND_W    = 2;
   localparam int VALUE_W   = 32;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int ACC_W     = PROD_W + $clog2(MAX_DIM);
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(DEPTH);

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_A  = 2'd0,
      KIND_LOAD_B  = 2'd1,
      KIND_COMPUTE = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_A     = 2'd0,
      CSR_INNER_SIZE = 2'd1,
      CSR_COLS_B     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               wr_a;
      logic               wr_b;
      logic [ADDR_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr_a;
      logic [ADDR_W-1:0]  rd_addr_b;
      logic               first;
      logic               last_term;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic               last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic result_loaded;
   } dp_status_type;

   // Element address within a store: row * MAX_DIM + col
   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM)) + ADDR_W'(col);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mmu_if.sv
// Valid/ready channel interfaces: request, response and register write.
`default_nettype none

interface mmu_req_if import mmu_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [IDX_W-1:0]          row;
   logic [IDX_W-1:0]          col;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, kind, row, col, value, input ready);
   modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface mmu_rsp_if import mmu_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic [IDX_W-1:0]          out_row;
   logic [IDX_W-1:0]          out_col;
   logic signed [VALUE_W-1:0] out_value;
   logic                      saturated;
   logic                      last;

   modport source (output valid, out_row, out_col, out_value, saturated, last,
                   input ready);
   modport sink   (input valid, out_row, out_col, out_value, saturated, last,
                   output ready);
endinterface

interface mmu_csr_if import mmu_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/matrix_multiply_unit.sv
// Loads are accepted back to back; a compute blocks further requests until it is done.
// A compute transfer emits rows*cols results, each after a start check, the inner read
// issue, then the read, multiply, accumulate and round/output stages.
// The shared 32x32 multiplier and single-read stores set the inner-term rate of 1/cycle.
// Reset (synchronous, active high): both stores read as zero, sizes return to 8,
// the output register empties; no clearing pass is needed.
`default_nettype none

module matrix_multiply_unit import mmu_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   mmu_req_if.sink   req_chan,
   mmu_rsp_if.source rsp_chan,
   mmu_csr_if.sink   csr_chan
);

   // controller drives the datapath by command only; status closes the loop
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: sizes, load decode, i/j/t counters
   mmu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .cmd      (dp_cmd),
      .status   (dp_status)
   );

   // stores, MAC pipeline and output register
   mmu_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dp_cmd),
      .status   (dp_status),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: rtl/mmu_ctrl.sv
// Controller: size registers, load decode and the element/term sequencer.
`default_nettype none

module mmu_ctrl import mmu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   mmu_req_if.sink      req_chan,
   mmu_csr_if.sink      csr_chan,
   output dp_cmd_type   cmd,
   input  wire dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_ISSUE,
      ST_FLUSH
   } state_type;

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] inner_ff, inner_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] t_ff, t_in;

   logic [DIM_W-1:0] m_eff, k_eff, n_eff;
   logic             req_fire;
   logic             last_row, last_col, last_term;

   // zero acts as one, oversize clamps to MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      if (v == '0)
         return DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM))
         return DIM_W'(MAX_DIM);
      else
         return v;
   endfunction

   assign m_eff = eff_dim(rows_ff);
   assign k_eff = eff_dim(inner_ff);
   assign n_eff = eff_dim(cols_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid & req_chan.ready;

   assign last_row  = (DIM_W'(i_ff) == m_eff - DIM_W'(1));
   assign last_col  = (DIM_W'(j_ff) == n_eff - DIM_W'(1));
   assign last_term = (DIM_W'(t_ff) == k_eff - DIM_W'(1));

   always_comb begin
      state_in = state_ff;
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      t_in     = t_ff;

      cmd           = '0;
      cmd.wr_addr   = elem_addr(req_chan.row, req_chan.col);
      cmd.wr_data   = req_chan.value;
      cmd.rd_addr_a = elem_addr(i_ff, t_ff);
      cmd.rd_addr_b = elem_addr(t_ff, j_ff);
      cmd.first     = (t_ff == '0);
      cmd.last_term = last_term;
      cmd.row       = i_ff;
      cmd.col       = j_ff;
      cmd.last      = last_row & last_col;

      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_ROWS_A:     rows_in  = csr_chan.data;
            CSR_INNER_SIZE: inner_in = csr_chan.data;
            CSR_COLS_B:     cols_in  = csr_chan.data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (kind_type'(req_chan.kind))
                  KIND_LOAD_A: begin
                     cmd.wr_a = (DIM_W'(req_chan.row) < m_eff) &&
                                (DIM_W'(req_chan.col) < k_eff);
                  end
                  KIND_LOAD_B: begin
                     cmd.wr_b = (DIM_W'(req_chan.row) < k_eff) &&
                                (DIM_W'(req_chan.col) < n_eff);
                  end
                  KIND_COMPUTE: begin
                     i_in     = '0;
                     j_in     = '0;
                     t_in     = '0;
                     state_in = ST_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_START: begin
            // one element in flight; wait until the output slot can take it
            if (status.out_free) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.rd_en = 1'b1;
            if (last_term) begin
               t_in     = '0;
               state_in = ST_FLUSH;
            end else begin
               t_in = t_ff + IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            if (status.result_loaded) begin
               if (last_row && last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_START;
                  if (last_col) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= DIM_RESET;
         inner_ff <= DIM_RESET;
         cols_ff  <= DIM_RESET;
         i_ff     <= '0;
         j_ff     <= '0;
         t_ff     <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         t_ff     <= t_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mmu_dp.sv
// Datapath: operand stores, multiplier, wide accumulator, round/saturate, output register.
`default_nettype none

module mmu_dp import mmu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire dp_cmd_type cmd,
   output dp_status_type status,
   mmu_rsp_if.source     rsp_chan
);

   typedef struct packed {
      logic             first;
      logic             last_term;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } tag_type;

   localparam logic [ACC_W-1:0] HALF_LSB = (ACC_W'(1) << FRAC_BITS) >> 1;

   logic [VALUE_W-1:0] mem_a [DEPTH];
   logic [VALUE_W-1:0] mem_b [DEPTH];

   logic [DEPTH-1:0]   vld_a_ff, vld_a_in;
   logic [DEPTH-1:0]   vld_b_ff, vld_b_in;

   // stage 1: read data
   logic [VALUE_W-1:0] a_rd_ff, b_rd_ff;
   logic               a_hit_ff, b_hit_ff;
   logic               s1_vld_ff;
   tag_type            s1_tag_ff;
   // stage 2: product
   logic signed [PROD_W-1:0] prod_ff;
   logic               s2_vld_ff;
   tag_type            s2_tag_ff;
   // stage 3: accumulated sum
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic               s3_vld_ff;
   tag_type            s3_tag_ff;
   // output register
   logic               rsp_vld_ff, rsp_vld_in;
   logic [IDX_W-1:0]   rsp_row_ff;
   logic [IDX_W-1:0]   rsp_col_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_sat_ff;
   logic               rsp_last_ff;

   logic signed [VALUE_W-1:0] op_a, op_b;
   logic signed [ACC_W-1:0]   rounded, shifted;
   logic                      fits;
   logic [VALUE_W-1:0]        fin_value;
   tag_type                   issue_tag;

   assign issue_tag = '{first: cmd.first, last_term: cmd.last_term,
                        row: cmd.row, col: cmd.col, last: cmd.last};

   // never-written entries read as zero
   assign vld_a_in = vld_a_ff | (cmd.wr_a ? (DEPTH'(1) << cmd.wr_addr) : '0);
   assign vld_b_in = vld_b_ff | (cmd.wr_b ? (DEPTH'(1) << cmd.wr_addr) : '0);

   assign op_a = a_hit_ff ? a_rd_ff : '0;
   assign op_b = b_hit_ff ? b_rd_ff : '0;

   always_comb begin
      if (s2_tag_ff.first)
         acc_in = ACC_W'(prod_ff);
      else
         acc_in = acc_ff + ACC_W'(prod_ff);
   end

   // round half up, arithmetic shift, clip to 32 bits
   assign rounded   = acc_ff + $signed(HALF_LSB);
   assign shifted   = rounded >>> FRAC_BITS;
   assign fits      = (&shifted[ACC_W-1:VALUE_W-1]) | ~(|shifted[ACC_W-1:VALUE_W-1]);
   assign fin_value = fits ? shifted[VALUE_W-1:0] :
                      (shifted[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                        : {1'b0, {(VALUE_W-1){1'b1}}});

   assign rsp_vld_in = s3_vld_ff ? 1'b1 : (rsp_vld_ff & ~rsp_chan.ready);

   assign status.out_free      = ~rsp_vld_ff | rsp_chan.ready;
   assign status.result_loaded = s3_vld_ff;

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.out_row   = rsp_row_ff;
   assign rsp_chan.out_col   = rsp_col_ff;
   assign rsp_chan.out_value = rsp_value_ff;
   assign rsp_chan.saturated = rsp_sat_ff;
   assign rsp_chan.last      = rsp_last_ff;

   // stores: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.wr_b) begin
         mem_b[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         a_rd_ff  <= mem_a[cmd.rd_addr_a];
         b_rd_ff  <= mem_b[cmd.rd_addr_b];
         a_hit_ff <= vld_a_ff[cmd.rd_addr_a];
         b_hit_ff <= vld_b_ff[cmd.rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= issue_tag;
      s2_tag_ff <= s1_tag_ff;
      s3_tag_ff <= s2_tag_ff;
      prod_ff   <= op_a * op_b;
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (s3_vld_ff) begin
         rsp_row_ff   <= s3_tag_ff.row;
         rsp_col_ff   <= s3_tag_ff.col;
         rsp_value_ff <= fin_value;
         rsp_sat_ff   <= ~fits;
         rsp_last_ff  <= s3_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff   <= '0;
         vld_b_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         vld_a_ff   <= vld_a_in;
         vld_b_ff   <= vld_b_in;
         s1_vld_ff  <= cmd.rd_en;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff & s2_tag_ff.last_term;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

endmodule

`default_nettype wire

FILE: test/mmu_result_checker.sv
// Channel monitor for the matrix multiply unit: predicts every result element and compares it.
`default_nettype none

module mmu_result_checker import mmu_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   mmu_req_if        req,
   mmu_rsp_if        rsp,
   mmu_csr_if        csr,
   output int        mismatches,
   output int        pending,
   output int        checked
);

   // 64-bit products, up to 8 terms: 72 bits is plenty and never wraps
   localparam int SUM_W = 72;

   typedef struct {
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [VALUE_W-1:0] value;
      logic               sat;
      logic               last;
   } product_elem_type;

   product_elem_type   product_q[$];
   logic [VALUE_W-1:0] mat_a [DEPTH];
   logic [VALUE_W-1:0] mat_b [DEPTH];
   logic [DIM_W-1:0]   size_rows;
   logic [DIM_W-1:0]   size_inner;
   logic [DIM_W-1:0]   size_cols;
   int                 printed;

   // register value in use: 0 acts as 1, above MAX_DIM acts as MAX_DIM
   function automatic int span(input logic [DIM_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return int'(raw);
   endfunction

   task automatic report(input string msg);
      if (printed < 30) $display("[%0t] mismatch: %s", $time, msg);
      printed++;
      mismatches++;
   endtask

   // queue C = A * B in row-major order, rounded half up and clipped to 32 bits
   task automatic multiply_stores();
      int                 m;
      int                 k;
      int                 n;
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] opa;
      logic signed [SUM_W-1:0] opb;
      product_elem_type   elem;
      m = span(size_rows);
      k = span(size_inner);
      n = span(size_cols);
      for (int i = 0; i < m; i++) begin
         for (int j = 0; j < n; j++) begin
            acc = '0;
            for (int t = 0; t < k; t++) begin
               opa = $signed(mat_a[i * MAX_DIM + t]);
               opb = $signed(mat_b[t * MAX_DIM + j]);
               acc = acc + opa * opb;
            end
            acc = acc + (SUM_W'(1) << (FRAC_BITS - 1));
            acc = acc >>> FRAC_BITS;
            elem.row   = IDX_W'(i);
            elem.col   = IDX_W'(j);
            elem.sat   = (acc[SUM_W-1:31] != {(SUM_W - 31){acc[SUM_W-1]}});
            elem.value = !elem.sat ? acc[31:0] :
                         (acc[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
            elem.last  = (i == m - 1) && (j == n - 1);
            product_q.insert(product_q.size(), elem);
         end
      end
   endtask

   always @(posedge clock) begin
      product_elem_type want;
      if (reset) begin
         for (int a = 0; a < DEPTH; a++) begin
            mat_a[a] = '0;
            mat_b[a] = '0;
         end
         size_rows  = DIM_RESET;
         size_inner = DIM_RESET;
         size_cols  = DIM_RESET;
         product_q.delete();
         mismatches = 0;
         checked    = 0;
         printed    = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_ROWS_A:     size_rows  = csr.data;
               CSR_INNER_SIZE: size_inner = csr.data;
               CSR_COLS_B:     size_cols  = csr.data;
               default:        ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            checked++;
            if (product_q.size() == 0) begin
               report($sformatf("unexpected element (%0d,%0d) value %h",
                                rsp.out_row, rsp.out_col, rsp.out_value));
            end else begin
               want = product_q.pop_front();
               if (rsp.out_row !== want.row || rsp.out_col !== want.col)
                  report($sformatf("position (%0d,%0d), want (%0d,%0d)",
                                   rsp.out_row, rsp.out_col, want.row, want.col));
               if (rsp.out_value !== want.value)
                  report($sformatf("(%0d,%0d) out_value %h, want %h",
                                   want.row, want.col, rsp.out_value, want.value));
               if (rsp.saturated !== want.sat)
                  report($sformatf("(%0d,%0d) saturated %b, want %b",
                                   want.row, want.col, rsp.saturated, want.sat));
               if (rsp.last !== want.last)
                  report($sformatf("(%0d,%0d) last %b, want %b",
                                   want.row, want.col, rsp.last, want.last));
            end
         end
         if (req.valid && req.ready) begin
            case (req.kind)
               KIND_LOAD_A: begin
                  if (req.row < span(size_rows) && req.col < span(size_inner))
                     mat_a[int'(req.row) * MAX_DIM + int'(req.col)] = req.value;
               end
               KIND_LOAD_B: begin
                  if (req.row < span(size_inner) && req.col < span(size_cols))
                     mat_b[int'(req.row) * MAX_DIM + int'(req.col)] = req.value;
               end
               KIND_COMPUTE: multiply_stores();
               default:      ;
            endcase
         end
      end
      pending = product_q.size();
   end

endmodule

`default_nettype wire

FILE: test/tb_matrix_multiply_unit.sv
// Top-level bench for the matrix multiply unit: stimulus, output pacing and verdict.
`default_nettype none

module tb_matrix_multiply_unit;
   import mmu_pkg::*;

   // kind and register index codes the block has no use for
   localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;

   // idle time after the drain, enough to cover any trailing work
   localparam int SETTLE_CYCLES = 24;
   localparam int ITEM_TARGET   = 320;
   localparam int HOLD_CYCLES   = 400;

   typedef enum int {PACE_FREE, PACE_MOSTLY, PACE_SPARSE, PACE_THIRD} sink_pace_type;

   logic clock;
   logic reset;

   mmu_req_if req_chan();
   mmu_rsp_if rsp_chan();
   mmu_csr_if csr_chan();

   int mismatches;
   int pending;
   int checked;

   int items_sent    = 0;
   int computes_sent = 0;
   int size_settings = 0;
   int work_items    = 0;
   int burst_left    = 0;
   int hold_requests = 0;

   int cur_m;
   int cur_k;
   int cur_n;

   matrix_multiply_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   mmu_result_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .csr        (csr_chan),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net, far above the slowest legal run.
   initial begin
      #40_000_000;
      $display("** matrix_multiply_unit: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Value pickers
   // ---------------------------------------------------------------------

   // mix of full-range words, corner values and small Q16.16 numbers (+/-4.0)
   function automatic logic [VALUE_W-1:0] rand_value();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick < 2) return $urandom;
      if (pick == 2) begin
         case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return VALUE_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
   endfunction

   // mostly small sizes keep the compute time down; a few go to the maximum
   function automatic int rand_size();
      case ($urandom_range(0, 9))
         0, 1:    return MAX_DIM;
         2:       return $urandom_range(4, MAX_DIM - 1);
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   // register encoding for a size: 1 may go as 0, MAX_DIM may go as anything above it
   function automatic logic [DIM_W-1:0] encode_size(input int eff);
      if (eff == 1 && $urandom_range(0, 2) == 0) return '0;
      if (eff == MAX_DIM && $urandom_range(0, 2) == 0)
         return DIM_W'($urandom_range(MAX_DIM + 1, 15));
      return DIM_W'(eff);
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Called right after the clock rises; returns once the
   // transfer has been taken, with valid still high so that the next
   // call can chain straight on.
   // ---------------------------------------------------------------------
   task automatic send_item(input logic [KIND_W-1:0]  kind,
                            input logic [IDX_W-1:0]   row,
                            input logic [IDX_W-1:0]   col,
                            input logic [VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         // long bursts now and then give stretches with no idling at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.kind  <= kind;
      req_chan.row   <= row;
      req_chan.col   <= col;
      req_chan.value <= value;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // Drop valid and wait until every predicted element has come back; then let
   // the block settle so that a register write finds it idle.
   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; valid stays high for the caller to chain or drop.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [DIM_W-1:0]     data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // Write all three sizes back to back; optionally hit the unused index first.
   task automatic resize(input logic [DIM_W-1:0] rows,
                         input logic [DIM_W-1:0] inner,
                         input logic [DIM_W-1:0] cols,
                         input bit               poke_unused);
      if (poke_unused) write_reg(CSR_UNUSED, 4'hF);
      write_reg(CSR_ROWS_A, rows);
      write_reg(CSR_INNER_SIZE, inner);
      write_reg(CSR_COLS_B, cols);
      csr_chan.valid <= 1'b0;
      size_settings++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: its own pacing pattern, plus a long hold-off whenever
   // the stimulus bumps hold_requests.
   // ---------------------------------------------------------------------
   initial begin
      sink_pace_type pace;
      int            pace_left;
      int            hold_left;
      int            holds_done;
      pace       = PACE_FREE;
      pace_left  = 0;
      hold_left  = 0;
      holds_done = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (pace_left == 0) begin
               pace      = sink_pace_type'($urandom_range(0, 3));
               pace_left = $urandom_range(30, 200);
            end
            pace_left--;
            case (pace)
               PACE_FREE:   rsp_chan.ready <= 1'b1;
               PACE_MOSTLY: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               PACE_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_chan.ready <= (pace_left % 3 == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and verdict
   // ---------------------------------------------------------------------
   initial begin
      int phase;
      int picks;
      phase = 0;

      req_chan.valid <= 1'b0;
      req_chan.kind  <= KIND_LOAD_A;
      req_chan.row   <= '0;
      req_chan.col   <= '0;
      req_chan.value <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_ROWS_A;
      csr_chan.data  <= '0;
      reset          <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, sizes at their reset value of 8 x 8 x 8 ---

      // stores must read as zero straight out of reset
      send_item(KIND_COMPUTE, 3'd0, 3'd0, 32'h0);
      // largest positive squared: C(0,0) clips high
      send_item(KIND_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send_item(KIND_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
      // most negative squared: 2^62 also clips high, at the far corner
      send_item(KIND_LOAD_A, 3'd7, 3'd7, 32'h8000_0000);
      send_item(KIND_LOAD_B, 3'd7, 3'd7, 32'h8000_0000);
      // exactly half an LSB rounds up to 1; minus half rounds up to 0
      send_item(KIND_LOAD_A, 3'd1, 3'd0, 32'h0000_0001);
      send_item(KIND_LOAD_B, 3'd0, 3'd1, 32'h0000_8000);
      send_item(KIND_LOAD_A, 3'd2, 3'd0, 32'hFFFF_FFFF);
      // negative clip at C(3,3)
      send_item(KIND_LOAD_A, 3'd3, 3'd5, 32'h8000_0000);
      send_item(KIND_LOAD_B, 3'd5, 3'd3, 32'h7FFF_FFFF);
      // unknown kind must not touch anything
      send_item(KIND_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_item(KIND_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);

      // 0 acts as 1 row, 15 and 9 clamp to 8; row 3 of A is now out of range
      wait_drain();
      resize(4'd0, 4'd15, 4'd9, 1'b1);
      send_item(KIND_LOAD_A, 3'd3, 3'd0, 32'h1234_5678);
      send_item(KIND_LOAD_A, 3'd0, 3'd7, 32'h0001_0000);
      send_item(KIND_COMPUTE, 3'd0, 3'd0, 32'h0);

      // a column vector result; B row 1 is out of range with inner size 1
      wait_drain();
      resize(4'd8, 4'd1, 4'd1, 1'b0);
      send_item(KIND_LOAD_B, 3'd1, 3'd0, 32'h5555_5555);
      send_item(KIND_LOAD_B, 3'd0, 3'd0, 32'h0002_0000);
      send_item(KIND_LOAD_A, 3'd5, 3'd0, 32'hFFFF_0000);
      send_item(KIND_COMPUTE, 3'd0, 3'd0, 32'h0);

      // Long output hold-off while computes and a load keep coming: the output
      // fills and the request side has to back up.
      wait_drain();
      resize(4'd4, 4'd4, 4'd4, 1'b0);
      hold_requests <= hold_requests + 1;
      send_item(KIND_COMPUTE, 3'd0, 3'd0, 32'h0);
      send_item(KIND_LOAD_A, 3'd3, 3'd3, 32'h0001_8000);
      send_item(KIND_COMPUTE, 3'd0, 3'd0, 32'h0);
      send_item(KIND_COMPUTE, 3'd0, 3'd0, 32'h0);
      wait_drain();

      // --- random phases: fill the stores within the sizes, then compute ---
      while (work_items < ITEM_TARGET) begin
         phase++;
         if (phase == 1 || $urandom_range(0, 1) == 0) begin
            wait_drain();
            cur_m = rand_size();
            cur_k = rand_size();
            cur_n = rand_size();
            resize(encode_size(cur_m), encode_size(cur_k), encode_size(cur_n), 1'b0);
         end else if ($urandom_range(0, 3) == 0) begin
            // hold back until everything is home, no register change
            wait_drain();
         end

         if (cur_m * cur_k <= 16 && cur_k * cur_n <= 16) begin
            // small sizes: touch (nearly) every element
            for (int r = 0; r < cur_m; r++)
               for (int c = 0; c < cur_k; c++)
                  if ($urandom_range(0, 6) != 0) begin
                     send_item(KIND_LOAD_A, IDX_W'(r), IDX_W'(c), rand_value());
                     work_items++;
                  end
            for (int r = 0; r < cur_k; r++)
               for (int c = 0; c < cur_n; c++)
                  if ($urandom_range(0, 6) != 0) begin
                     send_item(KIND_LOAD_B, IDX_W'(r), IDX_W'(c), rand_value());
                     work_items++;
                  end
         end else begin
            // large sizes: refresh a scattering of elements only
            repeat (12) begin
               send_item(KIND_LOAD_A, IDX_W'($urandom_range(0, cur_m - 1)),
                         IDX_W'($urandom_range(0, cur_k - 1)), rand_value());
               send_item(KIND_LOAD_B, IDX_W'($urandom_range(0, cur_k - 1)),
                         IDX_W'($urandom_range(0, cur_n - 1)), rand_value());
               work_items += 2;
            end
         end

         // noise: loads anywhere in the 8 x 8 grid and the unknown kind
         repeat ($urandom_range(0, 2)) begin
            picks = $urandom_range(0, 2);
            send_item((picks == 0) ? KIND_LOAD_A : (picks == 1) ? KIND_LOAD_B : KIND_UNUSED,
                      IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                      rand_value());
         end

         // compute ignores its other fields; randomize them anyway
         repeat ($urandom_range(1, 2)) begin
            send_item(KIND_COMPUTE, IDX_W'($urandom_range(0, 7)),
                      IDX_W'($urandom_range(0, 7)), $urandom);
            work_items++;
         end
      end

      wait_drain();
      @(negedge clock);

      $display("Run: %0d request transfers (%0d computes), %0d size settings,",
               items_sent, computes_sent, size_settings);
      $display("%0d elements checked. Included zero/over-range sizes, ignored loads, ",
               checked, "clipping both ways, half-LSB rounding and a long output hold-off.");
      if (mismatches == 0 && pending == 0) begin
         $display("** matrix_multiply_unit: PASSED **");
      end else begin
         $display("** matrix_multiply_unit: FAILED **");
      end
      $finish;
   end

   // computes are counted on transfer so the summary reflects what the block took
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready && req_chan.kind == KIND_COMPUTE)
         computes_sent <= computes_sent + 1;
   end

endmodule

`default_nettype wire
